[hw/rtl/accel_tilt_shake_detector_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tilt and shake detector
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_SHAKE_DETECTOR_TOP_ASSERT_SVH
`define ACCEL_TILT_SHAKE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ATSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ATSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/atsd_pkg.sv]
// ----------------------------------------------------------------------------
// atsd_pkg
// Types, codes and constants of the tilt and shake detector.
// ----------------------------------------------------------------------------
package atsd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int AXIS_W     = 17;
  localparam int TILT_THR_W = 16;
  localparam int SHAKE_THR_W = 17;
  localparam int MAG_W      = 17;
  localparam int SQ_W       = 2 * AXIS_W;
  localparam int RES_W      = SQ_W + 1;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MAG_W-1:0]       ONE_G         = 17'd16384;
  localparam logic [TILT_THR_W-1:0]  TILT_THR_RST  = 16'd8192;
  localparam logic [SHAKE_THR_W-1:0] SHAKE_THR_RST = 17'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THR = 3'd4;

  typedef enum logic [2:0] {
    DIR_FLAT  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  typedef enum logic {
    KIND_TILT  = 1'b0,
    KIND_SHAKE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DECIDE,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]    offset_x;
    logic signed [SAMPLE_W-1:0]    offset_y;
    logic signed [SAMPLE_W-1:0]    offset_z;
    logic        [TILT_THR_W-1:0]  tilt_threshold;
    logic        [SHAKE_THR_W-1:0] shake_threshold;
  } cfg_t;

  typedef struct packed {
    logic                     tilt_change;
    dir_t                     direction;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } entry_t;

endpackage

[hw/rtl/atsd_front.sv]
// ----------------------------------------------------------------------------
// atsd_front
// Applies axis offsets, classifies tilt and flags direction changes.
// ----------------------------------------------------------------------------
module atsd_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  atsd_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [atsd_pkg::SAMPLE_W-1:0]   x_sample,
  input  logic signed [atsd_pkg::SAMPLE_W-1:0]   y_sample,
  input  logic signed [atsd_pkg::SAMPLE_W-1:0]   z_sample,
  output logic                                   push,
  input  logic                                   queue_full,
  output atsd_pkg::entry_t                       entry
);

  localparam int CMP_W = atsd_pkg::AXIS_W + 1;

  atsd_pkg::dir_t prev_direction;
  atsd_pkg::dir_t dir;

  logic signed [atsd_pkg::AXIS_W-1:0] x_corr;
  logic signed [atsd_pkg::AXIS_W-1:0] y_corr;
  logic signed [atsd_pkg::AXIS_W-1:0] z_corr;
  logic signed [CMP_W-1:0] thr_pos;
  logic signed [CMP_W-1:0] thr_neg;
  logic signed [CMP_W-1:0] x_ext;
  logic signed [CMP_W-1:0] y_ext;

  assign x_corr = atsd_pkg::AXIS_W'(x_sample) + atsd_pkg::AXIS_W'(cfg.offset_x);
  assign y_corr = atsd_pkg::AXIS_W'(y_sample) + atsd_pkg::AXIS_W'(cfg.offset_y);
  assign z_corr = atsd_pkg::AXIS_W'(z_sample) + atsd_pkg::AXIS_W'(cfg.offset_z);

  assign thr_pos = $signed({2'b00, cfg.tilt_threshold});
  assign thr_neg = -thr_pos;
  assign x_ext   = CMP_W'(x_corr);
  assign y_ext   = CMP_W'(y_corr);

  always_comb begin
    priority if (x_ext > thr_pos) begin
      dir = atsd_pkg::DIR_RIGHT;
    end else if (x_ext < thr_neg) begin
      dir = atsd_pkg::DIR_LEFT;
    end else if (y_ext > thr_pos) begin
      dir = atsd_pkg::DIR_UP;
    end else if (y_ext < thr_neg) begin
      dir = atsd_pkg::DIR_DOWN;
    end else begin
      dir = atsd_pkg::DIR_FLAT;
    end
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  assign entry.tilt_change = (dir != prev_direction);
  assign entry.direction   = dir;
  assign entry.x           = x_corr;
  assign entry.y           = y_corr;
  assign entry.z           = z_corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_direction <= atsd_pkg::DIR_FLAT;
    end else if (push) begin
      prev_direction <= dir;
    end
  end

endmodule

[hw/rtl/atsd_queue.sv]
// ----------------------------------------------------------------------------
// atsd_queue
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
module atsd_queue #(
  parameter int DEPTH = atsd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  atsd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output atsd_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  atsd_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/atsd_back.sv]
// ----------------------------------------------------------------------------
// atsd_back
// Squared magnitude, iterative root, shake test and event output.
// ----------------------------------------------------------------------------
module atsd_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [atsd_pkg::SHAKE_THR_W-1:0]        shake_threshold,
  input  logic                                    q_valid,
  input  atsd_pkg::entry_t                        q_head,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output atsd_pkg::kind_t                         event_kind,
  output atsd_pkg::dir_t                          direction,
  output logic signed [atsd_pkg::AXIS_W-1:0]      x_corrected,
  output logic signed [atsd_pkg::AXIS_W-1:0]      y_corrected,
  output logic signed [atsd_pkg::AXIS_W-1:0]      z_corrected,
  output logic                                    last_of_run
);

  localparam int SQ_W  = atsd_pkg::SQ_W;
  localparam int RES_W = atsd_pkg::RES_W;
  localparam int AX_W  = atsd_pkg::AXIS_W;
  localparam int MAG_W = atsd_pkg::MAG_W;
  localparam int IT_W  = $clog2(atsd_pkg::SQRT_STEPS);

  atsd_pkg::back_state_t state;
  atsd_pkg::back_state_t state_next;

  atsd_pkg::entry_t cur;
  logic [1:0]       sq_cnt;
  logic [IT_W-1:0]  iter;
  logic [SQ_W-1:0]  prod;
  logic [SQ_W-1:0]  acc;
  logic [SQ_W-1:0]  rem;
  logic [RES_W-1:0] res;
  logic [SQ_W-1:0]  bitw;
  logic [MAG_W-1:0] prev_magnitude;
  logic             shake_pend;

  logic signed [AX_W-1:0] axis_sel;
  logic [AX_W-1:0]        axis_abs;
  logic [RES_W-1:0]       trial;
  logic                   take;
  logic [MAG_W-1:0]       mag;
  logic [MAG_W-1:0]       diff;
  logic                   shake;

  logic load_entry;
  logic load_tilt;
  logic load_shake;
  logic clear_pend;

  always_comb begin
    unique case (sq_cnt)
      2'd0:    axis_sel = cur.x;
      2'd1:    axis_sel = cur.y;
      default: axis_sel = cur.z;
    endcase
  end

  assign axis_abs = axis_sel[AX_W-1] ? AX_W'(-axis_sel) : AX_W'(axis_sel);
  assign trial    = res + RES_W'(bitw);
  assign take     = (RES_W'(rem) >= trial);
  assign mag      = res[MAG_W-1:0];
  assign diff     = (mag >= prev_magnitude) ? (mag - prev_magnitude) : (prev_magnitude - mag);
  assign shake    = (diff >= shake_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_entry = 1'b0;
    load_tilt  = 1'b0;
    load_shake = 1'b0;
    clear_pend = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      atsd_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          load_entry = 1'b1;
          state_next = atsd_pkg::ST_SQUARE;
        end
      end
      atsd_pkg::ST_SQUARE: begin
        if (sq_cnt == 2'd3) begin
          state_next = atsd_pkg::ST_ROOT;
        end
      end
      atsd_pkg::ST_ROOT: begin
        if (iter == IT_W'(atsd_pkg::SQRT_STEPS - 1)) begin
          state_next = atsd_pkg::ST_DECIDE;
        end
      end
      atsd_pkg::ST_DECIDE: begin
        if (cur.tilt_change) begin
          load_tilt  = 1'b1;
          state_next = atsd_pkg::ST_EMIT;
        end else if (shake) begin
          load_shake = 1'b1;
          state_next = atsd_pkg::ST_EMIT;
        end else begin
          state_next = atsd_pkg::ST_IDLE;
        end
      end
      atsd_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (shake_pend) begin
            load_shake = 1'b1;
            clear_pend = 1'b1;
          end else begin
            state_next = atsd_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = atsd_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_entry) begin
      cur    <= q_head;
      sq_cnt <= '0;
      acc    <= '0;
    end
    if (state == atsd_pkg::ST_SQUARE) begin
      sq_cnt <= sq_cnt + 2'd1;
      if (sq_cnt != 2'd3) begin
        prod <= SQ_W'(axis_abs) * SQ_W'(axis_abs);
      end
      if (sq_cnt != 2'd0) begin
        acc <= acc + prod;
      end
      if (sq_cnt == 2'd3) begin
        rem  <= acc + prod;
        res  <= '0;
        bitw <= SQ_W'(1) << (SQ_W - 2);
        iter <= '0;
      end
    end
    if (state == atsd_pkg::ST_ROOT) begin
      iter <= iter + IT_W'(1);
      bitw <= bitw >> 2;
      if (take) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + RES_W'(bitw);
      end else begin
        res <= res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_magnitude <= atsd_pkg::ONE_G;
      shake_pend     <= 1'b0;
    end else begin
      if (state == atsd_pkg::ST_DECIDE) begin
        prev_magnitude <= mag;
        shake_pend     <= cur.tilt_change && shake;
      end else if (clear_pend) begin
        shake_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_tilt) begin
      event_kind  <= atsd_pkg::KIND_TILT;
      direction   <= cur.direction;
      x_corrected <= cur.x;
      y_corrected <= cur.y;
      z_corrected <= cur.z;
      last_of_run <= !shake;
    end else if (load_shake) begin
      event_kind  <= atsd_pkg::KIND_SHAKE;
      direction   <= atsd_pkg::DIR_FLAT;
      x_corrected <= '0;
      y_corrected <= '0;
      z_corrected <= '0;
      last_of_run <= 1'b1;
    end
  end

endmodule

[hw/rtl/accel_tilt_shake_detector_top.sv]
// ----------------------------------------------------------------------------
// accel_tilt_shake_detector_top
// Accelerometer tilt and shake detector with stream ports.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel, one three-axis request per transfer.
// Each sample is offset corrected and tilt classified on acceptance, then
// queued. The back end squares and sums the axes, takes the floor root one
// result bit per cycle and decides the events. A sample yields zero, one or
// two events on m_axis: a tilt event when the direction changes, then a shake
// event when the magnitude moved by at least the shake threshold; tlast marks
// the final event of a sample. The first event follows the square, root and
// decide states; the back end takes a new sample only once the events of the
// last one are taken. Two queued samples let the input keep accepting while
// the back end works or while m_axis is stalled; a stalled event holds until
// taken. Reset clears the queue, sets direction to flat, magnitude to one g
// and the registers to their defaults. The user must write the registers
// through cfg_we only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module accel_tilt_shake_detector_top #(
  parameter int QUEUE_DEPTH = atsd_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // x_sample[15:0], y_sample[31:16], z_sample[47:32]
  input  logic [atsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // direction[2:0], x_corrected[19:3], y_corrected[36:20], z_corrected[53:37], zero pad
  output logic [atsd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // event_kind[0]
  output logic                                 m_axis_tuser,
  // last_of_run
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we,
  input  logic [atsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [atsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SW = atsd_pkg::SAMPLE_W;

  atsd_pkg::cfg_t   cfg;
  atsd_pkg::entry_t push_entry;
  atsd_pkg::entry_t head;
  logic             push;
  logic             full;
  logic             not_empty;
  logic             pop;

  atsd_pkg::kind_t             event_kind;
  atsd_pkg::dir_t              direction;
  logic signed [atsd_pkg::AXIS_W-1:0] x_corrected;
  logic signed [atsd_pkg::AXIS_W-1:0] y_corrected;
  logic signed [atsd_pkg::AXIS_W-1:0] z_corrected;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x        <= '0;
      cfg.offset_y        <= '0;
      cfg.offset_z        <= '0;
      cfg.tilt_threshold  <= atsd_pkg::TILT_THR_RST;
      cfg.shake_threshold <= atsd_pkg::SHAKE_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atsd_pkg::REG_OFFSET_X:  cfg.offset_x        <= cfg_data[SW-1:0];
        atsd_pkg::REG_OFFSET_Y:  cfg.offset_y        <= cfg_data[SW-1:0];
        atsd_pkg::REG_OFFSET_Z:  cfg.offset_z        <= cfg_data[SW-1:0];
        atsd_pkg::REG_TILT_THR:  cfg.tilt_threshold  <= cfg_data[atsd_pkg::TILT_THR_W-1:0];
        atsd_pkg::REG_SHAKE_THR: cfg.shake_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  atsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .x_sample   (s_axis_tdata[SW-1:0]),
    .y_sample   (s_axis_tdata[2*SW-1:SW]),
    .z_sample   (s_axis_tdata[3*SW-1:2*SW]),
    .push       (push),
    .queue_full (full),
    .entry      (push_entry)
  );

  atsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  atsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .shake_threshold (cfg.shake_threshold),
    .q_valid         (not_empty),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .event_kind      (event_kind),
    .direction       (direction),
    .x_corrected     (x_corrected),
    .y_corrected     (y_corrected),
    .z_corrected     (z_corrected),
    .last_of_run     (m_axis_tlast)
  );

  assign m_axis_tuser = event_kind;
  assign m_axis_tdata = {2'b00, z_corrected, y_corrected, x_corrected, direction};

endmodule

[hw/rtl/atsd_checker.sv]
// ----------------------------------------------------------------------------
// atsd_checker
// Port-level checks of the tilt and shake detector event stream.
// ----------------------------------------------------------------------------
`include "accel_tilt_shake_detector_top_assert.svh"

module atsd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [atsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);

  // a stalled event keeps its contents
  `ATSD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled event changed")

  // only a tilt event can be followed by another event of the same sample
  `ATSD_ASSERT_NOW(a_nonlast_is_tilt, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == atsd_pkg::KIND_TILT, "non-final event is not a tilt event")

  // a shake event is final and carries no direction or axes
  `ATSD_ASSERT_NOW(a_shake_shape, clk, rst, m_axis_tvalid && (m_axis_tuser == atsd_pkg::KIND_SHAKE), m_axis_tlast && (m_axis_tdata == '0), "malformed shake event")

  // a taken tilt event that is not final is followed by its shake event
  `ATSD_ASSERT_NEXT(a_shake_follows, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == atsd_pkg::KIND_SHAKE), "shake event missing after tilt")

endmodule

bind accel_tilt_shake_detector_top atsd_checker u_atsd_checker (.*);
